>>> rtl/sorted_open_list_queue_unit_assert.svh
// Assertion macros for the sorted open list queue unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SORTED_OPEN_LIST_QUEUE_UNIT_ASSERT_SVH
`define SORTED_OPEN_LIST_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SOLQ_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("solq assertion failed");
`define SOLQ_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("solq assertion failed");
`else
`define SOLQ_ASSERT_NOW(lbl, cond, prop)
`define SOLQ_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

>>> rtl/solq_pkg.sv
// Shared constants and types for the sorted open list queue unit.
// No dependencies.
`timescale 1ns / 1ps

package solq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int ID_BITS_DEF   = 16;
    localparam int COST_BITS_DEF = 16;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic       list_empty;
    } solq_flags_t;

endpackage

>>> rtl/solq_if.sv
// Handshake channels of the sorted open list queue unit: request and response.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps

interface solq_req_if #(
    parameter int ID_BITS   = 16,
    parameter int COST_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           cmd;
    logic [ID_BITS-1:0]   node_id;
    logic [COST_BITS-1:0] f_cost;

    modport source (output valid, cmd, node_id, f_cost, input ready);
    modport sink   (input valid, cmd, node_id, f_cost, output ready);
endinterface

interface solq_rsp_if #(
    parameter int ID_BITS   = 16,
    parameter int COST_BITS = 16,
    parameter int CNT_BITS  = 7
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic                 found;
    logic [ID_BITS-1:0]   popped_id;
    logic [ID_BITS-1:0]   head_id;
    logic [COST_BITS-1:0] head_cost;
    logic                 list_empty;
    logic [CNT_BITS-1:0]  entry_count;

    modport source (output valid, status, found, popped_id, head_id, head_cost,
                    list_empty, entry_count, input ready);
    modport sink   (input valid, status, found, popped_id, head_id, head_cost,
                    list_empty, entry_count, output ready);
endinterface

>>> rtl/solq_ram.sv
// Entry store: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module solq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/solq_seq.sv
// Sequencer and shared compare unit: scans, shifts and writes the entry store.
// Depends on solq_pkg.
`timescale 1ns / 1ps

module solq_seq #(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 16,
    parameter int COST_BITS = 16,
    parameter int AW        = 6,
    parameter int CNT_W     = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [2:0]                  req_cmd,
    input  logic [ID_BITS-1:0]          req_id,
    input  logic [COST_BITS-1:0]        req_cost,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [ID_BITS+COST_BITS-1:0] rd_data,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [ID_BITS+COST_BITS-1:0] wr_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output solq_pkg::solq_flags_t       res_flags,
    output logic [ID_BITS-1:0]          res_popped,
    output logic [ID_BITS-1:0]          res_head_id,
    output logic [COST_BITS-1:0]        res_head_cost,
    output logic [CNT_W-1:0]            res_count
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SHUP = 6'b000100,
        S_PUT  = 6'b001000,
        S_SHDN = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pv_reg, pv_next;
    logic [AW-1:0]        pidx_reg, pidx_next;
    logic [1:0]           status_reg, status_next;
    logic                 found_reg, found_next;
    logic [ID_BITS-1:0]   popped_reg, popped_next;
    logic [ID_BITS-1:0]   head_id_reg;
    logic [COST_BITS-1:0] head_cost_reg;

    logic [ID_BITS-1:0]   rd_id;
    logic [COST_BITS-1:0] rd_cost;
    logic                 hit;
    logic                 more;
    logic                 full;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     pidx_wide;

    assign rd_id     = rd_data[ID_BITS+COST_BITS-1:COST_BITS];
    assign rd_cost   = rd_data[COST_BITS-1:0];
    assign hit       = pv_reg && ((cmd_reg == solq_pkg::CMD_INSERT) ? (rd_cost > cost_reg)
                                                                    : (rd_id == id_reg));
    assign more      = idx_reg < count_reg;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign pidx_wide = CNT_W'(pidx_reg);
    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_FIN;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        cost_next   = cost_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        status_next = status_reg;
        found_next  = found_reg;
        popped_next = popped_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {id_reg, cost_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req_cmd;
                    id_next     = req_id;
                    cost_next   = req_cost;
                    status_next = solq_pkg::ST_OK;
                    found_next  = 1'b0;
                    popped_next = '0;
                    idx_next    = '0;
                    pos_next    = '0;
                    pv_next     = 1'b0;
                    case (req_cmd)
                        solq_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = solq_pkg::ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_SHUP;
                            end
                        end
                        solq_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = solq_pkg::ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        solq_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = solq_pkg::ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                popped_next = head_id_reg;
                                idx_next    = CNT_W'(1);
                                state_next  = S_SHDN;
                            end
                        end
                        solq_pkg::CMD_REMOVE, solq_pkg::CMD_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pv_next = 1'b0;
                    case (cmd_reg)
                        solq_pkg::CMD_INSERT:
                        begin
                            pos_next   = pidx_wide;
                            idx_next   = count_reg;
                            state_next = S_SHUP;
                        end
                        solq_pkg::CMD_REMOVE:
                        begin
                            pos_next   = pidx_wide;
                            idx_next   = pidx_wide + CNT_W'(1);
                            state_next = S_SHDN;
                        end
                        default:
                        begin
                            found_next = 1'b1;
                            state_next = S_FIN;
                        end
                    endcase
                end
                else if (!more)
                begin
                    pv_next = 1'b0;
                    case (cmd_reg)
                        solq_pkg::CMD_INSERT:
                        begin
                            pos_next   = count_reg;
                            idx_next   = count_reg;
                            state_next = S_SHUP;
                        end
                        solq_pkg::CMD_REMOVE:
                        begin
                            status_next = solq_pkg::ST_NOT_FOUND;
                            state_next  = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end

            // open a slot: entry i-1 moves to i, from the tail down to pos+1
            S_SHUP:
            begin
                if (pv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg;
                    wr_data = rd_data;
                end
                if (idx_reg > pos_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_dec[AW-1:0];
                    pidx_next = idx_reg[AW-1:0];
                    pv_next   = 1'b1;
                    idx_next  = idx_dec;
                end
                else
                begin
                    pv_next    = 1'b0;
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                count_next = count_reg + CNT_W'(1);
                state_next = S_FIN;
            end

            // close a slot: entry i moves to i-1, from pos+1 up to the tail
            S_SHDN:
            begin
                if (pv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg;
                    wr_data = rd_data;
                end
                if (more)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    pidx_next = idx_dec[AW-1:0];
                    pv_next   = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pv_next    = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        cost_reg   <= cost_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        popped_reg <= popped_next;
        // shadow copy of slot 0
        if (wr_en && (wr_addr == '0))
        begin
            head_id_reg   <= wr_data[ID_BITS+COST_BITS-1:COST_BITS];
            head_cost_reg <= wr_data[COST_BITS-1:0];
        end
    end

    always_comb
    begin
        res_flags.status     = status_reg;
        res_flags.found      = found_reg;
        res_flags.list_empty = count_reg == '0;
        res_popped           = popped_reg;
        res_head_id          = res_flags.list_empty ? '0 : head_id_reg;
        res_head_cost        = res_flags.list_empty ? '0 : head_cost_reg;
        res_count            = count_reg;
    end

endmodule

>>> rtl/sorted_open_list_queue_unit.sv
// Sorted open list queue unit, top level: store, sequencer, response register.
// Depends on solq_pkg, solq_if, solq_ram, solq_seq and the assertion header.
`timescale 1ns / 1ps
`include "sorted_open_list_queue_unit_assert.svh"

// Bounded list of (node_id, f_cost) entries kept in ascending cost order, with
// push front, sorted insert, pop, remove and contains. One request beat gives
// one response beat carrying status, head entry and count. The unit takes one
// request at a time; all work runs through a single-port-read, single-port-
// write entry store that moves or compares one entry per cycle. A search visits
// entries from the head, then a shift moves every entry behind the insert or
// removal point.
// A response waiting in the output register does not block the next request.
// No clearing pass is needed after reset.
module sorted_open_list_queue_unit #(
    parameter int DEPTH     = solq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = solq_pkg::ID_BITS_DEF,
    parameter int COST_BITS = solq_pkg::COST_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    solq_req_if.sink     req,
    solq_rsp_if.source   rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = ID_BITS + COST_BITS;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic                  res_valid;
    logic                  res_ready;
    solq_pkg::solq_flags_t res_flags;
    logic [ID_BITS-1:0]    res_popped;
    logic [ID_BITS-1:0]    res_head_id;
    logic [COST_BITS-1:0]  res_head_cost;
    logic [CNT_W-1:0]      res_count;

    logic                  out_valid_reg;
    solq_pkg::solq_flags_t out_flags_reg;
    logic [ID_BITS-1:0]    out_popped_reg;
    logic [ID_BITS-1:0]    out_head_id_reg;
    logic [COST_BITS-1:0]  out_head_cost_reg;
    logic [CNT_W-1:0]      out_count_reg;

    solq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    solq_seq #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .COST_BITS (COST_BITS),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_cmd       (req.cmd),
        .req_id        (req.node_id),
        .req_cost      (req.f_cost),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_flags     (res_flags),
        .res_popped    (res_popped),
        .res_head_id   (res_head_id),
        .res_head_cost (res_head_cost),
        .res_count     (res_count)
    );

    // output register: loads when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_flags_reg     <= res_flags;
            out_popped_reg    <= res_popped;
            out_head_id_reg   <= res_head_id;
            out_head_cost_reg <= res_head_cost;
            out_count_reg     <= res_count;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_flags_reg.status;
    assign rsp.found       = out_flags_reg.found;
    assign rsp.list_empty  = out_flags_reg.list_empty;
    assign rsp.popped_id   = out_popped_reg;
    assign rsp.head_id     = out_head_id_reg;
    assign rsp.head_cost   = out_head_cost_reg;
    assign rsp.entry_count = out_count_reg;

    `SOLQ_ASSERT_NOW(a_empty_matches_count, rsp.valid, rsp.list_empty == (rsp.entry_count == '0))
    `SOLQ_ASSERT_NOW(a_full_only_at_depth, rsp.valid && (rsp.status == solq_pkg::ST_FULL), rsp.entry_count == CNT_W'(DEPTH))
    `SOLQ_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `SOLQ_ASSERT_NOW(a_empty_head_zero, rsp.valid && rsp.list_empty, (rsp.head_id == '0) && (rsp.head_cost == '0))

endmodule

>>> tb/sv/sorted_open_list_queue_unit_tb.sv
// Self-checking testbench for sorted_open_list_queue_unit: directed table, then phased random ops.
// Every response beat is checked, against its table entry for typed probes, else against an in-bench model of the list.
// Depends on solq_pkg, solq_if and the RTL top level.
`timescale 1ns / 1ps

module sorted_open_list_queue_unit_tb;

    localparam int LIST_DEPTH    = solq_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 1080;
    localparam int PHASE_LEN     = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 100;
    localparam int GAP_PCT       = 8;
    localparam int CALM_FIRST    = 300;
    localparam int CALM_LAST     = 549;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} load_phase_e;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] popped_id;
        logic [15:0] head_id;
        logic [15:0] head_cost;
        logic        list_empty;
        logic [6:0]  entry_count;
    } list_result_t;

    typedef struct packed {
        logic [2:0]   cmd;
        logic [15:0]  node_id;
        logic [15:0]  f_cost;
        bit           typed;
        list_result_t want;
    } probe_row_t;

    logic clk;
    logic rst_n = 1'b0;

    solq_req_if #(.ID_BITS(16), .COST_BITS(16)) req_ch ();
    solq_rsp_if #(.ID_BITS(16), .COST_BITS(16), .CNT_BITS(7)) rsp_ch ();

    sorted_open_list_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [15:0]  list_ids [LIST_DEPTH];
    logic [15:0]  list_costs [LIST_DEPTH];
    int           list_len;
    int           peak_len;
    list_result_t pending_results [$];
    probe_row_t   probe_rows [$];
    bit           no_gaps;
    int           mismatch_count;
    int           items_sent;
    int           results_seen;
    int           full_hits;
    int           empty_hits;
    int           miss_hits;
    int           found_hits;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_result_t make_result(logic [1:0] status, logic found,
                                                 logic [15:0] popped, logic [15:0] hid,
                                                 logic [15:0] hcost, logic empty,
                                                 logic [6:0] count);
        list_result_t r;
        r.status      = status;
        r.found       = found;
        r.popped_id   = popped;
        r.head_id     = hid;
        r.head_cost   = hcost;
        r.list_empty  = empty;
        r.entry_count = count;
        return r;
    endfunction

    function automatic int index_of_id(logic [15:0] id);
        for (int i = 0; i < list_len; i++)
            if (list_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < list_len; i++)
        begin
            list_ids[i]   = list_ids[i + 1];
            list_costs[i] = list_costs[i + 1];
        end
        list_len--;
    endfunction

    function automatic list_result_t apply_list_op(logic [2:0] op, logic [15:0] id,
                                                   logic [15:0] cost);
        list_result_t r;
        int           pos;
        r   = '0;
        pos = 0;
        case (op)
            solq_pkg::CMD_PUSH, solq_pkg::CMD_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = solq_pkg::ST_FULL;
                else
                begin
                    if (op == solq_pkg::CMD_INSERT)
                        while (pos < list_len && list_costs[pos] <= cost)
                            pos++;
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_ids[i]   = list_ids[i - 1];
                        list_costs[i] = list_costs[i - 1];
                    end
                    list_ids[pos]   = id;
                    list_costs[pos] = cost;
                    list_len++;
                    if (list_len > peak_len)
                        peak_len = list_len;
                end
            end
            solq_pkg::CMD_POP:
            begin
                if (list_len == 0)
                    r.status = solq_pkg::ST_EMPTY;
                else
                begin
                    r.popped_id = list_ids[0];
                    drop_slot(0);
                end
            end
            solq_pkg::CMD_REMOVE:
            begin
                pos = index_of_id(id);
                if (pos < 0)
                    r.status = solq_pkg::ST_NOT_FOUND;
                else
                    drop_slot(pos);
            end
            solq_pkg::CMD_FIND:
                r.found = (index_of_id(id) >= 0);
            default: ;
        endcase
        r.head_id     = (list_len != 0) ? list_ids[0] : 16'h0;
        r.head_cost   = (list_len != 0) ? list_costs[0] : 16'h0;
        r.list_empty  = (list_len == 0);
        r.entry_count = list_len[6:0];
        return r;
    endfunction

    task automatic add_probe(logic [2:0] op, logic [15:0] id, logic [15:0] cost,
                             bit typed, list_result_t want);
        probe_row_t row;
        row.cmd     = op;
        row.node_id = id;
        row.f_cost  = cost;
        row.typed   = typed;
        row.want    = want;
        probe_rows.push_back(row);
    endtask

    task automatic send_beat(logic [2:0] op, logic [15:0] id, logic [15:0] cost,
                             bit typed, list_result_t want);
        list_result_t model_out;
        while (!no_gaps && $urandom_range(99) < GAP_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= op;
        req_ch.node_id <= id;
        req_ch.f_cost  <= cost;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        model_out = apply_list_op(op, id, cost);
        pending_results.push_back(typed ? want : model_out);
        items_sent++;
    endtask

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
        end
    endtask

    task automatic check_result();
        list_result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected response beat %0d: head 0x%0h count %0d",
                         results_seen, rsp_ch.head_id, rsp_ch.entry_count);
            return;
        end
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(rsp_ch.status));
        check_field("found", 16'(want.found), 16'(rsp_ch.found));
        check_field("popped_id", want.popped_id, rsp_ch.popped_id);
        check_field("head_id", want.head_id, rsp_ch.head_id);
        check_field("head_cost", want.head_cost, rsp_ch.head_cost);
        check_field("list_empty", 16'(want.list_empty), 16'(rsp_ch.list_empty));
        check_field("entry_count", 16'(want.entry_count), 16'(rsp_ch.entry_count));
        case (want.status)
            solq_pkg::ST_FULL:      full_hits++;
            solq_pkg::ST_EMPTY:     empty_hits++;
            solq_pkg::ST_NOT_FOUND: miss_hits++;
            default:                if (want.found) found_hits++;
        endcase
    endtask

    function automatic logic [2:0] pick_cmd(load_phase_e phase);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        case (phase)
            PH_FILL:
                return (roll < 60) ? solq_pkg::CMD_INSERT :
                       (roll < 78) ? solq_pkg::CMD_PUSH :
                       (roll < 86) ? solq_pkg::CMD_POP :
                       (roll < 93) ? solq_pkg::CMD_REMOVE : solq_pkg::CMD_FIND;
            PH_DRAIN:
                return (roll < 55) ? solq_pkg::CMD_POP :
                       (roll < 75) ? solq_pkg::CMD_REMOVE :
                       (roll < 85) ? solq_pkg::CMD_FIND :
                       (roll < 94) ? solq_pkg::CMD_INSERT : solq_pkg::CMD_PUSH;
            default:
                return (roll < 35) ? solq_pkg::CMD_INSERT :
                       (roll < 45) ? solq_pkg::CMD_PUSH :
                       (roll < 65) ? solq_pkg::CMD_POP :
                       (roll < 82) ? solq_pkg::CMD_REMOVE : solq_pkg::CMD_FIND;
        endcase
    endfunction

    function automatic logic [15:0] pick_id(logic [2:0] op);
        if ((op == solq_pkg::CMD_REMOVE || op == solq_pkg::CMD_FIND) && list_len > 0 &&
            $urandom_range(99) < 65)
            return list_ids[$urandom_range(list_len - 1)];
        if ($urandom_range(1))
            return 16'($urandom_range(31));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_cost();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 16'($urandom_range(15));
        if (roll < 60)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // response side: random backpressure, checks every accepted beat
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_result();
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                         quiet_cycles, pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0]   op;
        load_phase_e  phase;
        list_result_t none;
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= solq_pkg::CMD_PUSH;
        req_ch.node_id <= 16'h0;
        req_ch.f_cost  <= 16'h0;
        none           = '0;
        list_len       = 0;
        peak_len       = 0;
        no_gaps        = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        results_seen   = 0;
        full_hits      = 0;
        empty_hits     = 0;
        miss_hits      = 0;
        found_hits     = 0;
        quiet_cycles   = 0;

        add_probe(solq_pkg::CMD_POP, 16'h0000, 16'h0000, 1,
                  make_result(solq_pkg::ST_EMPTY, 0, 16'h0, 16'h0, 16'h0, 1, 7'd0));
        add_probe(solq_pkg::CMD_REMOVE, 16'h0005, 16'h0000, 1,
                  make_result(solq_pkg::ST_NOT_FOUND, 0, 16'h0, 16'h0, 16'h0, 1, 7'd0));
        add_probe(solq_pkg::CMD_FIND, 16'h0000, 16'h0000, 1,
                  make_result(solq_pkg::ST_OK, 0, 16'h0, 16'h0, 16'h0, 1, 7'd0));
        add_probe(CMD_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 1,
                  make_result(solq_pkg::ST_OK, 0, 16'h0, 16'h0, 16'h0, 1, 7'd0));
        add_probe(solq_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 1,
                  make_result(solq_pkg::ST_OK, 0, 16'h0, 16'hFFFF, 16'hFFFF, 0, 7'd1));
        add_probe(solq_pkg::CMD_INSERT, 16'h0000, 16'h0000, 1,
                  make_result(solq_pkg::ST_OK, 0, 16'h0, 16'h0000, 16'h0000, 0, 7'd2));
        add_probe(solq_pkg::CMD_INSERT, 16'h1234, 16'h8000, 0, none);
        // equal cost goes behind the earlier entry
        add_probe(solq_pkg::CMD_INSERT, 16'h2222, 16'h8000, 0, none);
        add_probe(solq_pkg::CMD_PUSH, 16'hAAAA, 16'hFFFF, 1,
                  make_result(solq_pkg::ST_OK, 0, 16'h0, 16'hAAAA, 16'hFFFF, 0, 7'd5));
        // list now out of order: lands ahead of the pushed head
        add_probe(solq_pkg::CMD_INSERT, 16'h5555, 16'h7FFF, 0, none);
        add_probe(solq_pkg::CMD_INSERT, 16'h0001, 16'hFFFF, 0, none);
        add_probe(solq_pkg::CMD_FIND, 16'h2222, 16'h0000, 0, none);
        add_probe(solq_pkg::CMD_FIND, 16'h9999, 16'h0000, 0, none);
        add_probe(solq_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 0, none);
        add_probe(solq_pkg::CMD_REMOVE, 16'h9999, 16'h0000, 0, none);
        add_probe(solq_pkg::CMD_REMOVE, 16'hFFFF, 16'h0000, 0, none);
        add_probe(CMD_SPARE_FIRST + 3'd1, 16'h5A5A, 16'hA5A5, 0, none);
        add_probe(CMD_SPARE_LAST, 16'h0000, 16'hFFFF, 0, none);
        add_probe(solq_pkg::CMD_POP, 16'h0000, 16'h0000, 0, none);
        // duplicate id: remove takes the one nearest the head
        add_probe(solq_pkg::CMD_PUSH, 16'h0000, 16'h0000, 0, none);
        add_probe(solq_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 0, none);
        repeat (4)
            add_probe(solq_pkg::CMD_POP, 16'h0000, 16'h0000, 0, none);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
            send_beat(probe_rows[i].cmd, probe_rows[i].node_id, probe_rows[i].f_cost,
                      probe_rows[i].typed, probe_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase   = load_phase_e'((n / PHASE_LEN) % 3);
            no_gaps = (n >= CALM_FIRST && n <= CALM_LAST);
            op      = pick_cmd(phase);
            send_beat(op, pick_id(op), pick_cost(), 0, none);
        end
        req_ch.valid <= 1'b0;
        no_gaps = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d request beats, %0d response beats, peak occupancy %0d of %0d",
                 items_sent, results_seen, peak_len, LIST_DEPTH);
        $display("full rejects %0d, empty pops %0d, missing ids %0d, successful finds %0d",
                 full_hits, empty_hits, miss_hits, found_hits);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sorted_open_list_queue_unit.f
+incdir+rtl
rtl/solq_pkg.sv
rtl/solq_if.sv
rtl/solq_ram.sv
rtl/solq_seq.sv
rtl/sorted_open_list_queue_unit.sv
tb/sv/sorted_open_list_queue_unit_tb.sv
